### sv/rgbhsv_pkg.sv
// Shared default sizes for the RGB to HSV converter.
`default_nettype none

package rgbhsv_pkg;

    localparam int unsigned CHANNEL_BITS_DEFAULT  = 8;
    localparam int unsigned FRACTION_BITS_DEFAULT = 16;

endpackage

`default_nettype wire

### sv/rgb_to_hsv_converter.sv
// Pipelined RGB to HSV converter with bit-per-stage dividers for hue and saturation.
//
// An accepted request passes the input register, the set-up entry, the division stages
// and the output register before its done strobe; the two long divisions, one quotient
// bit per stage, set that depth. Throughput: one request per clock; busy is never raised,
// and the receiver cannot stall, so results leave in request order one per cycle.
// Reset (rst_n low, asynchronous) clears every valid bit; payload registers are not reset.
`default_nettype none

module rgb_to_hsv_converter
    import rgbhsv_pkg::*;
#(
    parameter int unsigned CHANNEL_BITS  = CHANNEL_BITS_DEFAULT,
    parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEFAULT
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [CHANNEL_BITS-1:0]    red,
    input  wire logic [CHANNEL_BITS-1:0]    green,
    input  wire logic [CHANNEL_BITS-1:0]    blue,
    output logic                            done,
    output logic [FRACTION_BITS-1:0]        hue,
    output logic [FRACTION_BITS:0]          saturation,
    output logic [CHANNEL_BITS-1:0]         brightness
);

    localparam int unsigned CB = CHANNEL_BITS;
    localparam int unsigned F  = FRACTION_BITS;
    // Remainder width: the hue divisor is 6*delta < 2^(CB+3), and a shifted
    // remainder stays below twice the divisor.
    localparam int unsigned RW = CB + 4;
    // Quotient width: saturation reaches 2^F, so one bit above the fraction.
    localparam int unsigned QW = F + 1;

    // Hue offsets of the green and blue sectors, one third and two thirds of a turn.
    localparam logic [F-1:0] THIRD_TURN      = F'(((1 << F) + 1) / 3);
    localparam logic [F-1:0] TWO_THIRDS_TURN = F'(((2 << F) + 1) / 3);

    // Everything one request carries through the division stages.
    typedef struct packed {
        logic [CB-1:0]   vmax;      // brightness, also the saturation divisor
        logic [CB+2:0]   hdiv;      // six times delta, the hue divisor
        logic [RW-1:0]   srem;      // saturation partial remainder
        logic [RW-1:0]   hrem;      // hue partial remainder
        logic [QW-1:0]   sq;        // saturation quotient bits so far
        logic [QW-1:0]   hq;        // hue magnitude quotient bits so far
        logic            neg;       // hue difference was negative
        logic [F-1:0]    offset;    // sector offset of the hue
        logic            gray;      // max equals min
    } div_t;

    // One restoring division step on both dividers. The first step compares the
    // dividend itself; every later step shifts a zero into the remainder first.
    function automatic div_t div_step(input div_t cur, input logic first);
        div_t           nxt;
        logic [RW-1:0]  s_trial;
        logic [RW-1:0]  h_trial;
        logic [RW-1:0]  s_div;
        logic [RW-1:0]  h_div;
        logic           s_bit;
        logic           h_bit;
        nxt     = cur;
        s_div   = {{(RW-CB){1'b0}}, cur.vmax};
        h_div   = {1'b0, cur.hdiv};
        s_trial = first ? cur.srem : {cur.srem[RW-2:0], 1'b0};
        h_trial = first ? cur.hrem : {cur.hrem[RW-2:0], 1'b0};
        s_bit   = (s_trial >= s_div);
        h_bit   = (h_trial >= h_div);
        nxt.srem = s_bit ? (s_trial - s_div) : s_trial;
        nxt.hrem = h_bit ? (h_trial - h_div) : h_trial;
        nxt.sq   = {cur.sq[QW-2:0], s_bit};
        nxt.hq   = {cur.hq[QW-2:0], h_bit};
        return nxt;
    endfunction

    // The pipeline never holds a request back.
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage 1: capture the incoming pixel.
    // ------------------------------------------------------------------
    logic           in_valid_reg;
    logic [CB-1:0]  red_reg;
    logic [CB-1:0]  green_reg;
    logic [CB-1:0]  blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= red;
        green_reg <= green;
        blue_reg  <= blue;
    end

    // ------------------------------------------------------------------
    // Stage 2: max, min, delta, hue sector and the dividends.
    // Ties for the largest channel go to red, then green.
    // ------------------------------------------------------------------
    div_t           setup;
    logic [CB-1:0]  vmax;
    logic [CB-1:0]  vmin;
    logic [CB-1:0]  delta;
    logic [CB+2:0]  delta_ext;
    logic [CB:0]    diff;
    logic [CB:0]    diff_abs;

    always_comb
    begin
        vmax = red_reg;
        if (green_reg > vmax)
        begin
            vmax = green_reg;
        end
        if (blue_reg > vmax)
        begin
            vmax = blue_reg;
        end

        vmin = red_reg;
        if (green_reg < vmin)
        begin
            vmin = green_reg;
        end
        if (blue_reg < vmin)
        begin
            vmin = blue_reg;
        end

        delta     = vmax - vmin;
        delta_ext = {3'b000, delta};

        setup = '0;
        if (red_reg == vmax)
        begin
            diff          = {1'b0, green_reg} - {1'b0, blue_reg};
            setup.offset  = '0;
        end
        else if (green_reg == vmax)
        begin
            diff          = {1'b0, blue_reg} - {1'b0, red_reg};
            setup.offset  = THIRD_TURN;
        end
        else
        begin
            diff          = {1'b0, red_reg} - {1'b0, green_reg};
            setup.offset  = TWO_THIRDS_TURN;
        end

        // The difference never exceeds delta in size, so its magnitude fits CB bits.
        diff_abs = diff[CB] ? (~diff + 1'b1) : diff;

        setup.vmax = vmax;
        setup.hdiv = (delta_ext << 2) + (delta_ext << 1);
        setup.srem = {{(RW-CB){1'b0}}, delta};
        setup.hrem = {{(RW-CB){1'b0}}, diff_abs[CB-1:0]};
        setup.neg  = diff[CB];
        setup.gray = (delta == '0);
    end

    // ------------------------------------------------------------------
    // Division stages: one quotient bit of both dividers per stage.
    // Entry 0 holds the set-up values; entry k+1 holds k+1 quotient bits.
    // ------------------------------------------------------------------
    div_t   div_reg  [0:QW];
    div_t   div_next [0:QW];
    logic   valid_reg [0:QW];

    assign div_next[0] = setup;

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        assign div_next[k+1] = div_step(div_reg[k], (k == 0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QW; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= in_valid_reg;
            for (int k = 0; k < QW; k++)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= QW; k++)
        begin
            div_reg[k] <= div_next[k];
        end
    end

    // ------------------------------------------------------------------
    // Output stage: floor toward minus infinity for a negative difference,
    // add the sector offset with wrap, and force gray pixels to zero.
    // ------------------------------------------------------------------
    logic           done_reg;
    logic [F-1:0]   hue_reg;
    logic [F-1:0]   hue_next;
    logic [F:0]     sat_reg;
    logic [F:0]     sat_next;
    logic [CB-1:0]  bright_reg;
    logic [F-1:0]   hue_mag;
    logic [F-1:0]   hue_signed;

    always_comb
    begin
        hue_mag    = div_reg[QW].hq[F-1:0] + {{(F-1){1'b0}}, |div_reg[QW].hrem};
        hue_signed = div_reg[QW].neg ? (~hue_mag + 1'b1) : div_reg[QW].hq[F-1:0];
        if (div_reg[QW].gray)
        begin
            hue_next = '0;
            sat_next = '0;
        end
        else
        begin
            hue_next = hue_signed + div_reg[QW].offset;
            sat_next = div_reg[QW].sq;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        hue_reg    <= hue_next;
        sat_reg    <= sat_next;
        bright_reg <= div_reg[QW].vmax;
    end

    assign done       = done_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign brightness = bright_reg;

endmodule

`default_nettype wire
